// File: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("%m: assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

// File: src/lae_pkg.sv
// Shared types and constants of the label adjacency extractor.
`default_nettype none
package lae_pkg;

   localparam int LABEL_W    = 6;
   localparam int CFG_W      = 11;
   localparam int NBR        = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // neighbor slots, in the order they are checked
   localparam int NBR_LEFT     = 0;
   localparam int NBR_UP_LEFT  = 1;
   localparam int NBR_UP       = 2;
   localparam int NBR_UP_RIGHT = 3;

   // register word index (byte address bit 2)
   localparam logic REG_IMAGE_WIDTH = 1'b0;

   localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET = 11'd640;

   typedef logic [LABEL_W-1:0] label_type;
   typedef logic [NBR-1:0]     nbr_mask_type;

   typedef struct packed {
      label_type              li;
      logic                   fs;
      label_type [NBR-1:0]    cand;
      nbr_mask_type           have;
   } pixel_type;

endpackage
`default_nettype wire

// File: src/label_adjacency_extractor.sv
// Top level of the label adjacency extractor: register port and pipeline wiring.
// Takes one region label per clock in raster order while req_stall is low and reports
// every label pair that becomes 8-connected for the first time in the frame, comparing
// each pixel with its left, upper-left, upper and upper-right neighbors. A pixel with
// new pairs waits in the input register while earlier pairs are pending. Its pairs
// pass the pending-pair stage into the result register, which hands out one pair per
// transfer. The previous row sits in a dual-read RAM read ahead from the next pixel's
// position; first-row pixels ignore it, so the line store needs no clearing pass; the
// adjacency matrix clears at once on reset and on frame start. image_width may only
// change while no pixel is in flight.
`default_nettype none
module label_adjacency_extractor #(
   parameter int NUM_LABELS = 64,
   parameter int MAX_WIDTH  = 1024
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [lae_pkg::LABEL_W-1:0]      req_label,
   input  wire logic                             req_frame_start,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [lae_pkg::LABEL_W-1:0]           rsp_this_label,
   output logic [lae_pkg::LABEL_W-1:0]           rsp_other_label,
   output logic                                  rsp_last,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [lae_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [lae_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [lae_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);

   logic [lae_pkg::CFG_W-1:0] width_ff, width_in;
   logic                      reg_hit;
   logic                      width_wr;

   logic                      s1_valid;
   lae_pkg::pixel_type        s1_pix;
   lae_pkg::nbr_mask_type     mask;
   logic                      s2_free;
   logic                      move;
   logic                      load;

   assign reg_hit  = csr_paddr[lae_pkg::CSR_ADDR_W-1:2] == lae_pkg::REG_IMAGE_WIDTH;
   assign width_wr = csr_psel && csr_penable && csr_pwrite && csr_pready && reg_hit;
   assign width_in = width_wr ? csr_pwdata[lae_pkg::CFG_W-1:0] : width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= lae_pkg::IMAGE_WIDTH_RESET;
      end else begin
         width_ff <= width_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = reg_hit ? lae_pkg::CSR_DATA_W'(width_ff) : '0;

   // a pixel with no new pair passes even while earlier pairs are still queued
   assign move = s1_valid && (mask == '0 || s2_free);
   assign load = move && mask != '0;

   lae_scan #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_scan (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_label       (req_label),
      .req_frame_start (req_frame_start),
      .width_ff        (width_ff),
      .width_in        (width_in),
      .s1_adv          (move),
      .req_stall       (req_stall),
      .s1_valid        (s1_valid),
      .s1_pix          (s1_pix)
   );

   lae_adj #(
      .NUM_LABELS (NUM_LABELS)
   ) u_adj (
      .clock (clock),
      .reset (reset),
      .pix   (s1_pix),
      .move  (move),
      .mask  (mask)
   );

   lae_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .load            (load),
      .pix             (s1_pix),
      .mask            (mask),
      .rsp_stall       (rsp_stall),
      .s2_free         (s2_free),
      .rsp_valid       (rsp_valid),
      .rsp_this_label  (rsp_this_label),
      .rsp_other_label (rsp_other_label),
      .rsp_last        (rsp_last)
   );

endmodule
`default_nettype wire

// File: src/lae_ram.sv
// Generic single-write, dual-read RAM with registered read data.
`default_nettype none
module lae_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_a_addr,
   input  wire logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic      [WIDTH-1:0]         rd_a_data,
   output logic      [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_data_ff;
   logic [WIDTH-1:0] rd_b_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_data_ff <= mem_ff[rd_a_addr];
      rd_b_data_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_data_ff;
   assign rd_b_data = rd_b_data_ff;

endmodule
`default_nettype wire

// File: src/lae_scan.sv
// Raster position, previous-row line store and neighbor gathering into the input register.
`default_nettype none
module lae_scan #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic [lae_pkg::LABEL_W-1:0]   req_label,
   input  wire logic                          req_frame_start,
   input  wire logic [lae_pkg::CFG_W-1:0]     width_ff,
   input  wire logic [lae_pkg::CFG_W-1:0]     width_in,
   input  wire logic                          s1_adv,
   output logic                               req_stall,
   output logic                               s1_valid,
   output lae_pkg::pixel_type                 s1_pix
);

   localparam int XW   = $clog2(MAX_WIDTH);
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int CMPW = (WW > lae_pkg::CFG_W) ? WW : lae_pkg::CFG_W;

   function automatic logic [WW-1:0] clamp_width(input logic [lae_pkg::CFG_W-1:0] w);
      logic [CMPW-1:0] wx;
      wx = CMPW'(w);
      if (wx == '0) begin
         clamp_width = WW'(1);
      end else if (wx > CMPW'(MAX_WIDTH)) begin
         clamp_width = WW'(MAX_WIDTH);
      end else begin
         clamp_width = WW'(wx);
      end
   endfunction

   logic [XW-1:0]        col_ff, col_in;
   logic                 first_ff, first_in;
   lae_pkg::label_type   left_ff, left_in;
   lae_pkg::label_type   up_left_ff, up_left_in;
   logic                 s1_valid_ff, s1_valid_in;
   lae_pkg::pixel_type   s1_pix_ff, s1_pix_in;
   logic                 byp_en_ff;
   logic [XW-1:0]        byp_addr_ff;
   lae_pkg::label_type   byp_data_ff;
   logic [XW-1:0]        rd_a_addr_ff, rd_b_addr_ff;

   logic [WW-1:0]        w_cur, w_nxt;
   logic                 accept;
   logic [XW-1:0]        col_start;
   logic                 first_start;
   logic                 wrap;
   logic [XW-1:0]        x;
   logic                 first;
   logic [WW-1:0]        x_plus;
   logic                 right_ok;
   lae_pkg::label_type   ram_a, ram_b;
   lae_pkg::label_type   up, up_right;
   logic [XW-1:0]        xn;
   logic [XW-1:0]        rd_a_addr, rd_b_addr;

   assign w_cur  = clamp_width(width_ff);
   assign w_nxt  = clamp_width(width_in);
   assign accept = req_valid && !req_stall;

   // frame start restarts the raster before the pixel is placed
   assign col_start   = req_frame_start ? '0 : col_ff;
   assign first_start = req_frame_start || first_ff;
   assign wrap        = WW'(col_start) >= w_cur;
   assign x           = wrap ? '0 : col_start;
   assign first       = wrap ? 1'b0 : first_start;
   assign x_plus      = WW'(x) + WW'(1);
   assign right_ok    = x_plus < w_cur;

   // the last edge's write is not yet visible in the read data
   assign up       = (byp_en_ff && byp_addr_ff == rd_a_addr_ff) ? byp_data_ff : ram_a;
   assign up_right = (byp_en_ff && byp_addr_ff == rd_b_addr_ff) ? byp_data_ff : ram_b;

   always_comb begin
      col_in     = col_ff;
      first_in   = first_ff;
      left_in    = left_ff;
      up_left_in = up_left_ff;
      if (accept) begin
         col_in     = right_ok ? XW'(x_plus) : '0;
         first_in   = right_ok ? first : 1'b0;
         left_in    = req_label;
         up_left_in = up;
      end
   end

   // line store is read ahead, from the position the next pixel will take
   assign xn        = (WW'(col_in) >= w_nxt) ? '0 : col_in;
   assign rd_a_addr = xn;
   assign rd_b_addr = xn + XW'(1);

   always_comb begin
      s1_pix_in.li                         = req_label;
      s1_pix_in.fs                         = req_frame_start;
      s1_pix_in.cand[lae_pkg::NBR_LEFT]     = left_ff;
      s1_pix_in.cand[lae_pkg::NBR_UP_LEFT]  = up_left_ff;
      s1_pix_in.cand[lae_pkg::NBR_UP]       = up;
      s1_pix_in.cand[lae_pkg::NBR_UP_RIGHT] = up_right;
      s1_pix_in.have[lae_pkg::NBR_LEFT]     = x != '0;
      s1_pix_in.have[lae_pkg::NBR_UP_LEFT]  = x != '0 && !first;
      s1_pix_in.have[lae_pkg::NBR_UP]       = !first;
      s1_pix_in.have[lae_pkg::NBR_UP_RIGHT] = !first && right_ok;
   end

   assign s1_valid_in = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         first_ff    <= 1'b1;
         left_ff     <= '0;
         up_left_ff  <= '0;
         s1_valid_ff <= 1'b0;
         byp_en_ff   <= 1'b0;
      end else begin
         col_ff      <= col_in;
         first_ff    <= first_in;
         left_ff     <= left_in;
         up_left_ff  <= up_left_in;
         s1_valid_ff <= s1_valid_in;
         byp_en_ff   <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff <= s1_pix_in;
      end
      byp_addr_ff  <= x;
      byp_data_ff  <= req_label;
      rd_a_addr_ff <= rd_a_addr;
      rd_b_addr_ff <= rd_b_addr;
   end

   lae_ram #(
      .WIDTH (lae_pkg::LABEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock     (clock),
      .wr_en     (accept),
      .wr_addr   (x),
      .wr_data   (req_label),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (ram_a),
      .rd_b_data (ram_b)
   );

   assign req_stall = s1_valid_ff && !s1_adv;
   assign s1_valid  = s1_valid_ff;
   assign s1_pix    = s1_pix_ff;

endmodule
`default_nettype wire

// File: src/lae_adj.sv
// Symmetric label adjacency matrix as a row of per-label cells, with new-pair detection.
`default_nettype none
module lae_adj #(
   parameter int NUM_LABELS = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lae_pkg::pixel_type   pix,
   input  wire logic                 move,
   output lae_pkg::nbr_mask_type     mask
);

   localparam int CW = $clog2(NUM_LABELS) + lae_pkg::LABEL_W;

   logic [NUM_LABELS-1:0] row_ff   [NUM_LABELS];
   logic [NUM_LABELS-1:0] row_in   [NUM_LABELS];
   logic [NUM_LABELS-1:0] valid_ff, valid_in;
   logic [NUM_LABELS-1:0] set_bits [NUM_LABELS];

   logic [NUM_LABELS-1:0] row_sel;
   logic [NUM_LABELS-1:0] known_row;
   logic [NUM_LABELS-1:0] li_oh;
   logic [NUM_LABELS-1:0] cand_oh  [lae_pkg::NBR];
   logic [NUM_LABELS-1:0] new_row;
   logic                  li_ok;
   lae_pkg::nbr_mask_type base;
   lae_pkg::nbr_mask_type dup;

   always_comb begin
      row_sel = '0;
      for (int r = 0; r < NUM_LABELS; r++) begin
         if (valid_ff[r] && CW'(pix.li) == CW'(r)) begin
            row_sel = row_sel | row_ff[r];
         end
      end
      // a frame start sees an empty matrix
      known_row = pix.fs ? '0 : row_sel;
      li_ok     = CW'(pix.li) < CW'(NUM_LABELS);
      for (int b = 0; b < NUM_LABELS; b++) begin
         li_oh[b] = CW'(pix.li) == CW'(b);
      end
      for (int k = 0; k < lae_pkg::NBR; k++) begin
         for (int b = 0; b < NUM_LABELS; b++) begin
            cand_oh[k][b] = CW'(pix.cand[k]) == CW'(b);
         end
         base[k] = pix.have[k] && pix.cand[k] != pix.li && li_ok
                   && CW'(pix.cand[k]) < CW'(NUM_LABELS)
                   && (known_row & cand_oh[k]) == '0;
      end
      // a label repeated among the neighbors counts once, at its first new slot
      for (int k = 0; k < lae_pkg::NBR; k++) begin
         dup[k] = 1'b0;
         for (int j = 0; j < k; j++) begin
            dup[k] = dup[k] || (base[j] && pix.cand[j] == pix.cand[k]);
         end
         mask[k] = base[k] && !dup[k];
      end
      new_row = '0;
      for (int k = 0; k < lae_pkg::NBR; k++) begin
         if (mask[k]) begin
            new_row = new_row | cand_oh[k];
         end
      end
   end

   // each cell sets its own bits: row li gets the new labels, each new label's row gets li
   always_comb begin
      for (int r = 0; r < NUM_LABELS; r++) begin
         set_bits[r] = (li_oh[r] ? new_row : '0) | (new_row[r] ? li_oh : '0);
         row_in[r]   = ((valid_ff[r] && !pix.fs) ? row_ff[r] : '0) | set_bits[r];
         valid_in[r] = move ? ((valid_ff[r] && !pix.fs) || set_bits[r] != '0) : valid_ff[r];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         for (int r = 0; r < NUM_LABELS; r++) begin
            row_ff[r] <= row_in[r];
         end
      end
   end

endmodule
`default_nettype wire

// File: src/lae_emit.sv
// Pending-pair stage and result register: one new pair per transfer.
`default_nettype none
module lae_emit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          load,
   input  wire lae_pkg::pixel_type            pix,
   input  wire lae_pkg::nbr_mask_type         mask,
   input  wire logic                          rsp_stall,
   output logic                               s2_free,
   output logic                               rsp_valid,
   output logic [lae_pkg::LABEL_W-1:0]        rsp_this_label,
   output logic [lae_pkg::LABEL_W-1:0]        rsp_other_label,
   output logic                               rsp_last
);

   lae_pkg::nbr_mask_type             pending_ff, pending_in;
   lae_pkg::label_type                li_ff;
   lae_pkg::label_type [lae_pkg::NBR-1:0] cand_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   lae_pkg::label_type                this_ff, other_ff;
   logic                              last_ff;

   logic                  out_free;
   logic                  send;
   lae_pkg::nbr_mask_type pick;
   lae_pkg::nbr_mask_type rest;
   lae_pkg::label_type    other_sel;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign send     = pending_ff != '0 && out_free;
   assign pick     = pending_ff & (~pending_ff + lae_pkg::nbr_mask_type'(1));
   assign rest     = pending_ff & ~pick;
   assign s2_free  = pending_ff == '0 || (send && rest == '0);

   always_comb begin
      other_sel = '0;
      for (int k = 0; k < lae_pkg::NBR; k++) begin
         if (pick[k]) begin
            other_sel = other_sel | cand_ff[k];
         end
      end
   end

   assign pending_in   = load ? mask : (send ? rest : pending_ff);
   assign rsp_valid_in = send ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         li_ff   <= pix.li;
         cand_ff <= pix.cand;
      end
      if (send) begin
         this_ff  <= li_ff;
         other_ff <= other_sel;
         last_ff  <= rest == '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_this_label  = this_ff;
   assign rsp_other_label = other_ff;
   assign rsp_last        = last_ff;

endmodule
`default_nettype wire

// File: src/lae_checker.sv
// Port-level checks of the label adjacency extractor, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module lae_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   input  wire logic                             req_stall,
   input  wire logic [lae_pkg::LABEL_W-1:0]      req_label,
   input  wire logic                             req_frame_start,
   input  wire logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   input  wire logic [lae_pkg::LABEL_W-1:0]      rsp_this_label,
   input  wire logic [lae_pkg::LABEL_W-1:0]      rsp_other_label,
   input  wire logic                             rsp_last,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [lae_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [lae_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input  wire logic [lae_pkg::CSR_DATA_W-1:0]   csr_prdata,
   input  wire logic                             csr_pready
);

   // held result keeps its payload
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_this_label) && $stable(rsp_other_label) && $stable(rsp_last))

   // a pair never joins a label with itself
   `ASSERT_SAME(a_pair_distinct, clock, reset, rsp_valid, rsp_this_label != rsp_other_label)

   // pairs of one pixel follow back to back with a different neighbor
   `ASSERT_NEXT(a_run_continues, clock, reset, rsp_valid && !rsp_stall && !rsp_last,
      rsp_valid && $stable(rsp_this_label) && rsp_other_label != $past(rsp_other_label))

   // width register reads back what was written
   `ASSERT_NEXT(a_width_readback, clock, reset,
      csr_psel && csr_penable && csr_pwrite && csr_pready
         && csr_paddr[lae_pkg::CSR_ADDR_W-1:2] == lae_pkg::REG_IMAGE_WIDTH,
      csr_paddr[lae_pkg::CSR_ADDR_W-1:2] != lae_pkg::REG_IMAGE_WIDTH
         || csr_prdata[lae_pkg::CFG_W-1:0] == $past(csr_pwdata[lae_pkg::CFG_W-1:0]))

endmodule

bind label_adjacency_extractor lae_checker u_checker (.*);
`default_nettype wire

// File: test/label_adjacency_extractor_tb.sv
// Self-checking testbench for the label adjacency extractor: directed and random frames.
module label_adjacency_extractor_tb;
   import lae_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LABELS     = 64;
   localparam int LINE_MAX   = 1024;
   localparam int STUCK_MAX  = 2000;
   localparam int DRAIN_WAIT = 8;
   localparam logic [CSR_ADDR_W-1:0] WIDTH_ADDR = {REG_IMAGE_WIDTH, 2'b00};

   typedef struct {
      label_type this_l;
      label_type other_l;
      logic      last;
   } pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   label_type req_label = '0;
   logic req_frame_start = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   label_type rsp_this_label;
   label_type rsp_other_label;
   logic rsp_last;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // predictor state
   logic [LABELS-1:0] adj_bits [LABELS];
   label_type row_store [LINE_MAX];
   label_type left_q, up_left_q;
   int unsigned col_q;
   bit first_row_q;
   logic [CFG_W-1:0] width_q;
   int unsigned filled_q;   // entries below this index have been written

   pair_type pending_pairs [$];
   int unsigned pixels_sent, pairs_checked, error_count;
   bit steady;              // no idling on either side while set

   label_adjacency_extractor dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 25);
   end

   function automatic int unsigned clamp_width(input logic [CFG_W-1:0] w);
      if (w < 1) return 1;
      if (w > LINE_MAX) return LINE_MAX;
      return w;
   endfunction

   // Works out the label pairs that this pixel makes adjacent for the first time.
   function automatic void track_adjacency(input label_type lab, input logic fs);
      int unsigned w, x, n;
      label_type up;
      label_type cand [4];
      bit have [4];
      pair_type found [4];
      if (fs) begin
         foreach (adj_bits[i]) adj_bits[i] = '0;
         col_q = 0;
         first_row_q = 1'b1;
      end
      w = clamp_width(width_q);
      x = col_q;
      if (x >= w) begin
         x = 0;
         first_row_q = 1'b0;
      end
      up = row_store[x];
      have[0] = x > 0;
      cand[0] = left_q;
      have[1] = x > 0 && !first_row_q;
      cand[1] = up_left_q;
      have[2] = !first_row_q;
      cand[2] = up;
      have[3] = !first_row_q && (x + 1) < w;
      cand[3] = ((x + 1) < w) ? row_store[x + 1] : '0;
      n = 0;
      for (int k = 0; k < 4; k++) begin
         if (have[k] && cand[k] != lab && !adj_bits[lab][cand[k]]) begin
            adj_bits[lab][cand[k]] = 1'b1;
            adj_bits[cand[k]][lab] = 1'b1;
            found[n].this_l = lab;
            found[n].other_l = cand[k];
            found[n].last = 1'b0;
            n++;
         end
      end
      for (int k = 0; k < n; k++) begin
         found[k].last = (k == n - 1);
         pending_pairs.push_back(found[k]);
      end
      row_store[x] = lab;
      if (x + 1 > filled_q) filled_q = x + 1;
      left_q = lab;
      up_left_q = up;
      x++;
      if (x >= w) begin
         col_q = 0;
         first_row_q = 1'b0;
      end else begin
         col_q = x;
      end
   endfunction

   // Called at a rising edge; returns at the edge of the transfer.
   task automatic send_pixel(input label_type lab, input logic fs);
      while (!steady && $urandom_range(0, 99) < 25) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_label <= lab;
      req_frame_start <= fs;
      @(negedge clock);
      while (req_stall !== 1'b0) @(negedge clock);
      @(posedge clock);
      track_adjacency(lab, fs);
      pixels_sent++;
   endtask

   task automatic drain_pairs();
      req_valid <= 1'b0;
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic check_image_width(input logic [CFG_W-1:0] want);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= WIDTH_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      if (csr_prdata[CFG_W-1:0] !== want) begin
         $display("%0t: image_width readback expected %0d actual %0d",
                  $time, want, csr_prdata[CFG_W-1:0]);
         error_count++;
      end
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_image_width(input logic [CFG_W-1:0] val);
      drain_pairs();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= WIDTH_ADDR;
      csr_pwdata <= CSR_DATA_W'(val);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      width_q = val;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      check_image_width(val);
   endtask

   task automatic test_reset_value();
      check_image_width(IMAGE_WIDTH_RESET);
   endtask

   // 3x3 image: one pixel sees four distinct neighbors, others hit repeats and equal labels.
   task automatic test_four_neighbors();
      label_type img [9] = '{6'd0, 6'd1, 6'd2, 6'd63, 6'd7, 6'd2, 6'd63, 6'd63, 6'd63};
      write_image_width(11'd3);
      foreach (img[i]) send_pixel(img[i], i == 0);
   endtask

   // Width zero behaves as a single column: only the pixel above counts.
   task automatic test_single_column();
      label_type img [5] = '{6'd5, 6'd5, 6'd9, 6'd63, 6'd0};
      write_image_width(11'd0);
      foreach (img[i]) send_pixel(img[i], i == 0);
   endtask

   // Width cut below the current column starts a new row; then a mid-row frame restart.
   task automatic test_width_shrink();
      label_type first_part [5] = '{6'd10, 6'd10, 6'd20, 6'd20, 6'd30};
      label_type second_part [5] = '{6'd20, 6'd30, 6'd10, 6'd11, 6'd12};
      write_image_width(11'd8);
      foreach (first_part[i]) send_pixel(first_part[i], i == 0);
      write_image_width(11'd3);
      foreach (second_part[i]) send_pixel(second_part[i], i == 4);
   endtask

   // All-ones width clamps to the line store size; a full row plus a few pixels.
   task automatic test_widest_rows();
      label_type lab;
      write_image_width(11'h7FF);
      for (int i = 0; i < LINE_MAX + 4; i++) begin
         lab = (i < LINE_MAX) ? label_type'(i / 100) : label_type'(63 - i % 2);
         send_pixel(lab, i == 0);
      end
   endtask

   // Region-like frames: labels mostly repeat left or upper neighbors, some noise.
   task automatic test_random_frames();
      int unsigned phase, count, target, n_pal, r;
      logic [CFG_W-1:0] w;
      label_type palette [6];
      label_type lab;
      logic fs;
      phase = 0;
      count = 0;
      while (count < 200) begin
         r = $urandom_range(0, 99);
         if (r < 8) w = '0;
         else if (r < 14) w = '1;
         else if (r < 18) w = 11'(LINE_MAX);
         else if (r < 22) w = 11'($urandom_range(13, 2046));
         else w = 11'($urandom_range(1, 12));
         write_image_width(w);
         steady = (phase == 3);
         n_pal = $urandom_range(2, 6);
         foreach (palette[i]) palette[i] = label_type'($urandom_range(0, LABELS - 1));
         target = $urandom_range(10, 40);
         for (int i = 0; i < target; i++) begin
            // a wider line than ever written must start a fresh frame
            fs = (i == 0 && (clamp_width(w) > filled_q || $urandom_range(0, 1) == 1))
                 || $urandom_range(0, 99) < 3;
            r = $urandom_range(0, 99);
            if (r < 40 && col_q > 0) lab = left_q;
            else if (r < 65 && col_q < filled_q) lab = row_store[col_q];
            else if (r < 90) lab = palette[$urandom_range(0, n_pal - 1)];
            else lab = label_type'($urandom_range(0, LABELS - 1));
            send_pixel(lab, fs);
         end
         count += target;
         phase++;
      end
      steady = 1'b0;
   endtask

   // each result transfer happens at the edge after this sample
   always @(negedge clock) begin
      pair_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_pairs.size() == 0) begin
            $display("%0t: unexpected pair this=%0d other=%0d last=%0b",
                     $time, rsp_this_label, rsp_other_label, rsp_last);
            error_count++;
         end else begin
            want = pending_pairs.pop_front();
            pairs_checked++;
            if (rsp_this_label !== want.this_l) begin
               $display("%0t: this_label expected %0d actual %0d",
                        $time, want.this_l, rsp_this_label);
               error_count++;
            end
            if (rsp_other_label !== want.other_l) begin
               $display("%0t: other_label expected %0d actual %0d",
                        $time, want.other_l, rsp_other_label);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last expected %0b actual %0b", $time, want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   initial begin
      int unsigned stuck;
      stuck = 0;
      while (stuck < STUCK_MAX) begin
         @(negedge clock);
         if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)
             || csr_psel)
            stuck = 0;
         else
            stuck++;
      end
      $display("%0t: no transfer for %0d cycles", $time, STUCK_MAX);
      $display("label_adjacency_extractor_tb: done, errors");
      $finish;
   end

   initial begin
      foreach (adj_bits[i]) adj_bits[i] = '0;
      foreach (row_store[i]) row_store[i] = '0;
      left_q = '0;
      up_left_q = '0;
      col_q = 0;
      first_row_q = 1'b1;
      width_q = IMAGE_WIDTH_RESET;
      filled_q = 0;
      pixels_sent = 0;
      pairs_checked = 0;
      error_count = 0;
      steady = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_value();
      test_four_neighbors();
      test_single_column();
      test_width_shrink();
      test_widest_rows();
      test_random_frames();
      drain_pairs();
      $display("Covered %0d pixels and %0d new label pairs", pixels_sent, pairs_checked);
      $display("over widths 0 to 2047, frame restarts, width cuts and random stalls.");
      if (error_count == 0)
         $display("label_adjacency_extractor_tb: done, clean");
      else
         $display("label_adjacency_extractor_tb: done, errors");
      $finish;
   end

endmodule

// File: label_adjacency_extractor.f
+incdir+src
src/lae_pkg.sv
src/lae_ram.sv
src/lae_scan.sv
src/lae_adj.sv
src/lae_emit.sv
src/label_adjacency_extractor.sv
src/lae_checker.sv
test/label_adjacency_extractor_tb.sv
